[hw/rtl/qsv_pkg.sv]
package qsv_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_QUBITS_DEF = 10;
  localparam int AMP_WIDTH_DEF  = 16;

  // Fixed field widths and number formats.
  localparam int FRAC_BITS = 14;
  localparam int COEF_W    = 16;
  localparam int ADDR_W    = 10;
  localparam int QUBIT_W   = 4;
  localparam int QN_W      = 5;
  localparam logic [QUBIT_W-1:0] QC_RESET = 4'd10;

  // Command codes.
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_GATE  = 2'd2;
  localparam logic [1:0] CMD_CNOT  = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_QUBIT = 2'd1;
  localparam logic [1:0] ST_CTRL  = 2'd2;
  localparam logic [1:0] ST_ADDR  = 2'd3;

  // Read address select.
  localparam logic [1:0] RD_ADDR = 2'd0;
  localparam logic [1:0] RD_LO   = 2'd1;
  localparam logic [1:0] RD_HI   = 2'd2;

  // Write address and data select.
  localparam logic [1:0] WR_CLEAR = 2'd0;
  localparam logic [1:0] WR_ITEM  = 2'd1;
  localparam logic [1:0] WR_LO    = 2'd2;
  localparam logic [1:0] WR_HI    = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_item;
    logic       clr_k;
    logic       inc_k;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       cap0;
    logic       cap1;
    logic       mul_en;
    logic       sum_en;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       out_load;
  } qsv_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic       err;
    logic       skip;
    logic       last;
    logic       k_full;
  } qsv_stat_t;

endpackage

[hw/rtl/qsv_ifs.sv]
interface qsv_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [9:0]         amp_address;
  logic [3:0]         qubit_a;
  logic [3:0]         qubit_b;
  logic signed [15:0] write_real;
  logic signed [15:0] write_imag;
  logic [31:0]        coef_00;
  logic [31:0]        coef_01;
  logic [31:0]        coef_10;
  logic [31:0]        coef_11;
  modport source(output valid, command, amp_address, qubit_a, qubit_b, write_real, write_imag,
                 coef_00, coef_01, coef_10, coef_11, input ready);
  modport sink(input valid, command, amp_address, qubit_a, qubit_b, write_real, write_imag,
               coef_00, coef_01, coef_10, coef_11, output ready);
endinterface

interface qsv_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [15:0] read_real;
  logic signed [15:0] read_imag;
  modport source(output valid, status, read_real, read_imag, input ready);
  modport sink(input valid, status, read_real, read_imag, output ready);
endinterface

interface qsv_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] qubit_count;
  modport source(output valid, qubit_count, input ready);
  modport sink(input valid, qubit_count, output ready);
endinterface

[hw/rtl/qsv_ram.sv]
module qsv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/qsv_datapath.sv]
module qsv_datapath import qsv_pkg::*; #(
  parameter int MAX_QUBITS = MAX_QUBITS_DEF,
  parameter int AMP_WIDTH  = AMP_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  qsv_cmd_t            cmd,
  output qsv_stat_t           stat,
  input  logic                cfg_we,
  input  logic [QUBIT_W-1:0]  cfg_qubit_count,
  input  logic [1:0]          in_command,
  input  logic [ADDR_W-1:0]   in_amp_address,
  input  logic [QUBIT_W-1:0]  in_qubit_a,
  input  logic [QUBIT_W-1:0]  in_qubit_b,
  input  logic signed [15:0]  in_write_real,
  input  logic signed [15:0]  in_write_imag,
  input  logic [31:0]         in_coef_00,
  input  logic [31:0]         in_coef_01,
  input  logic [31:0]         in_coef_10,
  input  logic [31:0]         in_coef_11,
  output logic [1:0]          out_status,
  output logic signed [15:0]  out_read_real,
  output logic signed [15:0]  out_read_imag
);

  localparam int AW = MAX_QUBITS;
  localparam int DW = 2 * AMP_WIDTH;
  localparam int PW = COEF_W + AMP_WIDTH;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] AMP_MAX =
    {{(SW-AMP_WIDTH+1){1'b0}}, {(AMP_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] AMP_MIN =
    {{(SW-AMP_WIDTH+1){1'b1}}, {(AMP_WIDTH-1){1'b0}}};

  // Floor by the fraction bits, then clamp to the amplitude range.
  function automatic logic signed [AMP_WIDTH-1:0] trunc_sat(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] q;
    q = s >>> FRAC_BITS;
    if (q > AMP_MAX) begin
      q = AMP_MAX;
    end else if (q < AMP_MIN) begin
      q = AMP_MIN;
    end
    return q[AMP_WIDTH-1:0];
  endfunction

  logic [QUBIT_W-1:0]        qc_r;
  logic [AW-1:0]             k_r;
  logic [1:0]                cmd_r;
  logic [ADDR_W-1:0]         addr_r;
  logic [QUBIT_W-1:0]        qa_r;
  logic [QUBIT_W-1:0]        qb_r;
  logic signed [15:0]        wre_r;
  logic signed [15:0]        wim_r;
  logic [31:0]               coef_r [4];
  logic signed [AMP_WIDTH-1:0] a0_re_r, a0_im_r, a1_re_r, a1_im_r;
  logic signed [PW-1:0]      prod_r [16];
  logic signed [SW-1:0]      sre_r [2];
  logic signed [SW-1:0]      sim_r [2];
  logic [1:0]                status_r;
  logic signed [15:0]        rre_r, rim_r;

  logic [QN_W-1:0]    n_eff;
  logic               qa_bad, qb_bad, addr_bad;
  logic [1:0]         status_c;
  logic [QUBIT_W-1:0] qsel;
  logic [AW-1:0]      low_mask, bit_mask, idx_lo, idx_hi, half_mask, item_addr;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [DW-1:0]      wr_data, rd_data;
  logic signed [AMP_WIDTH-1:0] rd_re, rd_im, item_re, item_im;
  logic signed [COEF_W-1:0]    cr [4];
  logic signed [COEF_W-1:0]    ci [4];

  // Effective qubit count and the checks on the held item.
  assign n_eff    = (QN_W'(qc_r) > QN_W'(MAX_QUBITS)) ? QN_W'(MAX_QUBITS) : QN_W'(qc_r);
  assign qa_bad   = QN_W'(qa_r) >= n_eff;
  assign qb_bad   = QN_W'(qb_r) >= n_eff;
  assign addr_bad = (addr_r >> n_eff) != '0;

  always_comb begin
    case (cmd_r)
      CMD_WRITE, CMD_READ: status_c = addr_bad ? ST_ADDR : ST_OK;
      CMD_GATE:            status_c = qa_bad ? ST_QUBIT : ST_OK;
      CMD_CNOT: begin
        if (qa_bad || qb_bad) begin
          status_c = ST_QUBIT;
        end else if (qa_r == qb_r) begin
          status_c = ST_CTRL;
        end else begin
          status_c = ST_OK;
        end
      end
      default: status_c = ST_OK;
    endcase
  end

  // Pair addresses: a zero bit is inserted into the pair counter at the paired qubit.
  assign qsel      = (cmd_r == CMD_GATE) ? qa_r : qb_r;
  assign bit_mask  = AW'(1) << qsel;
  assign low_mask  = bit_mask - AW'(1);
  assign idx_lo    = ((k_r & ~low_mask) << 1) | (k_r & low_mask);
  assign idx_hi    = idx_lo | bit_mask;
  assign half_mask = (AW'(1) << (n_eff - QN_W'(1))) - AW'(1);
  assign item_addr = AW'(addr_r);

  assign stat.cmd    = cmd_r;
  assign stat.err    = status_c != ST_OK;
  assign stat.skip   = (cmd_r == CMD_CNOT) && ((idx_lo & (AW'(1) << qa_r)) == '0);
  assign stat.last   = k_r == half_mask;
  assign stat.k_full = &k_r;

  // Control registers: qubit count and pair counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qc_r <= QC_RESET;
      k_r  <= '0;
    end else begin
      if (cfg_we) begin
        qc_r <= cfg_qubit_count;
      end
      if (cmd.clr_k) begin
        k_r <= '0;
      end else if (cmd.inc_k) begin
        k_r <= k_r + AW'(1);
      end
    end
  end

  // Coefficient halves.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      cr[c] = coef_r[c][31:16];
      ci[c] = coef_r[c][15:0];
    end
  end

  assign rd_re   = rd_data[DW-1:AMP_WIDTH];
  assign rd_im   = rd_data[AMP_WIDTH-1:0];
  assign item_re = AMP_WIDTH'(wre_r);
  assign item_im = AMP_WIDTH'(wim_r);

  // Memory address and data selection.
  always_comb begin
    case (cmd.rd_sel)
      RD_LO:   rd_addr = idx_lo;
      RD_HI:   rd_addr = idx_hi;
      default: rd_addr = item_addr;
    endcase
    case (cmd.wr_sel)
      WR_CLEAR: begin
        wr_addr = k_r;
        wr_data = '0;
      end
      WR_ITEM: begin
        wr_addr = item_addr;
        wr_data = {item_re, item_im};
      end
      WR_LO: begin
        wr_addr = idx_lo;
        wr_data = (cmd_r == CMD_GATE) ? {trunc_sat(sre_r[0]), trunc_sat(sim_r[0])}
                                      : {a1_re_r, a1_im_r};
      end
      default: begin
        wr_addr = idx_hi;
        wr_data = (cmd_r == CMD_GATE) ? {trunc_sat(sre_r[1]), trunc_sat(sim_r[1])}
                                      : {a0_re_r, a0_im_r};
      end
    endcase
  end

  qsv_ram #(
    .WIDTH(DW),
    .DEPTH(1 << AW)
  ) u_store (
    .clk    (clk),
    .wr_en  (cmd.wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (cmd.rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Item, operand, product, sum and result registers.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cmd_r     <= in_command;
      addr_r    <= in_amp_address;
      qa_r      <= in_qubit_a;
      qb_r      <= in_qubit_b;
      wre_r     <= in_write_real;
      wim_r     <= in_write_imag;
      coef_r[0] <= in_coef_00;
      coef_r[1] <= in_coef_01;
      coef_r[2] <= in_coef_10;
      coef_r[3] <= in_coef_11;
    end
    if (cmd.cap0) begin
      a0_re_r <= rd_re;
      a0_im_r <= rd_im;
    end
    if (cmd.cap1) begin
      a1_re_r <= rd_re;
      a1_im_r <= rd_im;
    end
    if (cmd.mul_en) begin
      for (int r = 0; r < 2; r++) begin
        prod_r[8*r+0] <= PW'(cr[2*r])   * PW'(a0_re_r);
        prod_r[8*r+1] <= PW'(ci[2*r])   * PW'(a0_im_r);
        prod_r[8*r+2] <= PW'(cr[2*r+1]) * PW'(a1_re_r);
        prod_r[8*r+3] <= PW'(ci[2*r+1]) * PW'(a1_im_r);
        prod_r[8*r+4] <= PW'(cr[2*r])   * PW'(a0_im_r);
        prod_r[8*r+5] <= PW'(ci[2*r])   * PW'(a0_re_r);
        prod_r[8*r+6] <= PW'(cr[2*r+1]) * PW'(a1_im_r);
        prod_r[8*r+7] <= PW'(ci[2*r+1]) * PW'(a1_re_r);
      end
    end
    if (cmd.sum_en) begin
      for (int r = 0; r < 2; r++) begin
        sre_r[r] <= SW'(prod_r[8*r+0]) - SW'(prod_r[8*r+1])
                  + SW'(prod_r[8*r+2]) - SW'(prod_r[8*r+3]);
        sim_r[r] <= SW'(prod_r[8*r+4]) + SW'(prod_r[8*r+5])
                  + SW'(prod_r[8*r+6]) + SW'(prod_r[8*r+7]);
      end
    end
    if (cmd.out_load) begin
      status_r <= status_c;
      if ((cmd_r == CMD_READ) && (status_c == ST_OK)) begin
        rre_r <= 16'(unsigned'(a0_re_r));
        rim_r <= 16'(unsigned'(a0_im_r));
      end else begin
        rre_r <= '0;
        rim_r <= '0;
      end
    end
  end

  assign out_status    = status_r;
  assign out_read_real = rre_r;
  assign out_read_imag = rim_r;

endmodule

[hw/rtl/qsv_ctrl.sv]
module qsv_ctrl import qsv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  qsv_stat_t stat,
  output qsv_cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_WRA   = 4'd3;
  localparam logic [3:0] S_RRD   = 4'd4;
  localparam logic [3:0] S_RCAP  = 4'd5;
  localparam logic [3:0] S_PRD0  = 4'd6;
  localparam logic [3:0] S_PRD1  = 4'd7;
  localparam logic [3:0] S_PCAP  = 4'd8;
  localparam logic [3:0] S_MUL   = 4'd9;
  localparam logic [3:0] S_SUM   = 4'd10;
  localparam logic [3:0] S_PWR0  = 4'd11;
  localparam logic [3:0] S_PWR1  = 4'd12;
  localparam logic [3:0] S_NEXT  = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  // Sequencer for the clear sweep, single accesses and the pair loop.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_CLEAR;
        cmd.inc_k  = 1'b1;
        if (stat.k_full) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.clr_k = 1'b1;
        if (stat.err) begin
          state_nxt = S_DONE;
        end else begin
          case (stat.cmd)
            CMD_WRITE: state_nxt = S_WRA;
            CMD_READ:  state_nxt = S_RRD;
            default:   state_nxt = S_PRD0;
          endcase
        end
      end
      S_WRA: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_ITEM;
        state_nxt  = S_DONE;
      end
      S_RRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_ADDR;
        state_nxt  = S_RCAP;
      end
      S_RCAP: begin
        cmd.cap0  = 1'b1;
        state_nxt = S_DONE;
      end
      S_PRD0: begin
        if (stat.skip) begin
          state_nxt = S_NEXT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LO;
          state_nxt  = S_PRD1;
        end
      end
      S_PRD1: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_HI;
        cmd.cap0   = 1'b1;
        state_nxt  = S_PCAP;
      end
      S_PCAP: begin
        cmd.cap1  = 1'b1;
        state_nxt = (stat.cmd == CMD_GATE) ? S_MUL : S_PWR0;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = S_PWR0;
      end
      S_PWR0: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_LO;
        state_nxt  = S_PWR1;
      end
      S_PWR1: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_HI;
        state_nxt  = S_NEXT;
      end
      S_NEXT: begin
        if (stat.last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.inc_k = 1'b1;
          state_nxt = S_PRD0;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result word held until the receiver takes it.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result word not presented after load");
  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_CHECK)
    else $error("accepted word not checked");
  a_err_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) && stat.err |=> state_r == S_DONE)
    else $error("failed command touched the store");
  a_mul_then_sum: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_en |=> cmd.sum_en)
    else $error("products not summed");
`endif

endmodule

[hw/rtl/qubit_state_vector_gate_engine_core.sv]
// State vector gate engine. Holds 2^qubit_count complex amplitudes.
// in_chan takes one command word: write or read one amplitude, apply a
// 2x2 complex gate to one qubit, or apply CNOT. Every command word gives
// exactly one result word on out_chan (status and, for a read, the data).
// cfg_chan writes the qubit count; it is always ready. The user must see
// that it is written only while the engine is idle; the block itself does
// not enforce this. After acceptance a write is checked and stored, a read
// is checked, read and captured, and a rejected command is only checked.
// A gate reads, captures, multiplies, sums and writes back each amplitude
// pair; CNOT swaps each pair whose control qubit (qubit_a) is one and skips
// the other pairs. in_chan is ready again in the cycle after the result is
// loaded. The state memory has one write port and one registered read port,
// and gate and CNOT share the pair sequencer; one command is in work at a
// time. After reset the memory is cleared, one entry per cycle, all
// 2^MAX_QUBITS entries, and in_chan.ready stays low meanwhile.
// A finished result waits in the output register while out_chan is
// stalled; the engine takes one more word meanwhile and holds its result
// back, with in_chan.ready low, until the waiting result has moved.
module qubit_state_vector_gate_engine_core import qsv_pkg::*; #(
  parameter int MAX_QUBITS = MAX_QUBITS_DEF,
  parameter int AMP_WIDTH  = AMP_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  qsv_in_if.sink    in_chan,
  qsv_out_if.source out_chan,
  qsv_cfg_if.sink   cfg_chan
);

  qsv_cmd_t  cmd;
  qsv_stat_t stat;

  assign cfg_chan.ready = 1'b1;

  qsv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .out_valid(out_chan.valid),
    .out_ready(out_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  qsv_datapath #(
    .MAX_QUBITS(MAX_QUBITS),
    .AMP_WIDTH (AMP_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_chan.valid),
    .cfg_qubit_count(cfg_chan.qubit_count),
    .in_command     (in_chan.command),
    .in_amp_address (in_chan.amp_address),
    .in_qubit_a     (in_chan.qubit_a),
    .in_qubit_b     (in_chan.qubit_b),
    .in_write_real  (in_chan.write_real),
    .in_write_imag  (in_chan.write_imag),
    .in_coef_00     (in_chan.coef_00),
    .in_coef_01     (in_chan.coef_01),
    .in_coef_10     (in_chan.coef_10),
    .in_coef_11     (in_chan.coef_11),
    .out_status     (out_chan.status),
    .out_read_real  (out_chan.read_real),
    .out_read_imag  (out_chan.read_imag)
  );

endmodule
